// ===== rtl/slcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types, parser phase codes and character constants for the SLCAN
// command line parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_DISCARD = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOWER  = 8'h20;
  localparam logic [7:0] CH_STD    = 8'h74;  // t
  localparam logic [7:0] CH_EXT    = 8'h54;  // T
  localparam logic [7:0] CH_STDRTR = 8'h72;  // r
  localparam logic [7:0] CH_EXTRTR = 8'h52;  // R
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_EIGHT  = 8'h38;

  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;

  localparam logic [31:0] EXT_FLAG = 32'h8000_0000;
  localparam logic [31:0] RTR_FLAG = 32'h4000_0000;

  typedef struct packed {
    logic [2:0]  phase;
    logic        is_extended;
    logic        is_remote;
    logic [31:0] id_accum;
    logic [3:0]  digit_count;
    logic [3:0]  len_held;
    logic [63:0] data_accum;
    logic [4:0]  nibble_count;
  } parse_state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

// ===== rtl/slcp_step.sv =====
// ----------------------------------------------------------------------------
// slcp_step
// Next-state and frame logic for one received character.
// ----------------------------------------------------------------------------
module slcp_step import slcp_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   c,
  output parse_state_t st_next,
  output logic         emit,
  output frame_t       frame
);

  function automatic parse_state_t idle_byte(input parse_state_t s, input logic [7:0] b);
    parse_state_t r;
    r = s;
    if (b == CH_CR) begin
      r.phase = PH_IDLE;
    end else if (b == CH_STD || b == CH_EXT || b == CH_STDRTR || b == CH_EXTRTR) begin
      r.is_extended  = ((b & CH_LOWER) == 8'h00);
      r.is_remote    = ((b | CH_LOWER) == CH_STDRTR);
      r.id_accum     = '0;
      r.digit_count  = '0;
      r.len_held     = '0;
      r.data_accum   = '0;
      r.nibble_count = '0;
      r.phase        = PH_ID;
    end else begin
      r.phase = PH_DISCARD;
    end
    return r;
  endfunction

  logic [4:0]   v;
  logic [3:0]   cnt_inc;
  logic [4:0]   nib_inc;
  logic [5:0]   sh;
  parse_state_t s;

  always_comb begin
    v       = hex_value(c);
    cnt_inc = st.digit_count + 4'd1;
    nib_inc = st.nibble_count + 5'd1;
    sh      = {st.nibble_count[3:1], ~st.nibble_count[0], 2'b00};
    s       = st;
    emit    = 1'b0;
    unique case (st.phase)
      PH_DISCARD: begin
        if (c == CH_CR) s.phase = PH_IDLE;
      end
      PH_ID: begin
        if (v[4]) begin
          s.phase = PH_IDLE;
        end else begin
          s.id_accum    = {st.id_accum[27:0], v[3:0]};
          s.digit_count = cnt_inc;
          if (cnt_inc >= (st.is_extended ? EXT_ID_DIGITS : STD_ID_DIGITS))
            s.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (st.is_remote) begin
          s.len_held   = '0;
          s.data_accum = '0;
          s.phase      = PH_IDLE;
          emit         = 1'b1;
        end else if (c < CH_ZERO || c > CH_EIGHT) begin
          s.phase = PH_IDLE;
        end else begin
          s.len_held     = c[3:0];
          s.data_accum   = '0;
          s.nibble_count = '0;
          if (c[3:0] == 4'd0) begin
            s.phase = PH_IDLE;
            emit    = 1'b1;
          end else begin
            s.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (v[4] || st.nibble_count[4]) begin
          s.phase = PH_IDLE;
        end else begin
          s.data_accum   = st.data_accum | ({60'd0, v[3:0]} << sh);
          s.nibble_count = nib_inc;
          if (nib_inc >= {st.len_held, 1'b0}) begin
            s.phase = PH_IDLE;
            emit    = 1'b1;
          end
        end
      end
      default: s = idle_byte(st, c);
    endcase

    frame.id   = s.id_accum | (s.is_extended ? EXT_FLAG : 32'd0)
                            | (s.is_remote ? RTR_FLAG : 32'd0);
    frame.len  = s.len_held;
    frame.data = s.data_accum;

    // remote frame: a length byte other than '0' is taken as the first byte of the next line
    if (st.phase == PH_LEN && st.is_remote && c != CH_ZERO) s = idle_byte(s, c);
    st_next = s;
  end

endmodule

// ===== rtl/slcan_ascii_to_can_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// slcan_ascii_to_can_frame_parser_core
// SLCAN ASCII command stream to CAN frame parser.
// ----------------------------------------------------------------------------
// Takes one character per request and one request per cycle while no frame
// waits unaccepted at the output. A character is captured in an input
// register, parsed from there by the combinational step logic, and a
// completed frame lands in the output register, from which it is offered.
// While a frame waits unaccepted in the output register, parsing stops; the
// input register takes at most one more character and the input then stalls
// until the frame is taken.
module slcan_ascii_to_can_frame_parser_core import slcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] frame_id,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_data
);

  logic         in_held;
  logic [7:0]   byte_held;
  parse_state_t st;
  parse_state_t st_next;
  logic         emit;
  frame_t       frame;
  logic         proc;

  slcp_step u_step (
    .st      (st),
    .c       (byte_held),
    .st_next (st_next),
    .emit    (emit),
    .frame   (frame)
  );

  assign proc     = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held   <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_ready) in_held <= in_valid;
      if (proc) st <= st_next;
      if (proc && emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_held <= rx_byte;
    if (proc && emit) begin
      frame_id   <= frame.id;
      frame_len  <= frame.len;
      frame_data <= frame.data;
    end
  end

endmodule

// ===== dv/tb_slcan_ascii_to_can_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_slcan_ascii_to_can_frame_parser_core
// Drives SLCAN command text into the parser one character per request and
// checks every emitted CAN frame. A behavioral parser inside the bench
// tracks each accepted character and queues the frames it should produce.
// Covers directed corner cases, random well-formed and broken lines,
// random idling on both sides, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_slcan_ascii_to_can_frame_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import slcp_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;

  slcan_ascii_to_can_frame_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_id   (frame_id),
    .frame_len  (frame_len),
    .frame_data (frame_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser mirror
  logic [2:0]  cur_phase;
  logic        cur_ext;
  logic        cur_rtr;
  logic [31:0] id_acc;
  logic [3:0]  id_digits;
  logic [3:0]  data_len;
  logic [63:0] data_acc;
  logic [4:0]  nibbles;
  frame_t      frames_due[$];

  int errors       = 0;
  int chars_sent   = 0;
  int line_chars   = 0;
  int frames_seen  = 0;
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  int rx_hold_req  = 0;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 4'd10);
  endfunction

  task automatic queue_frame();
    frame_t f;
    f.id   = id_acc | (cur_ext ? EXT_FLAG : 32'h0) | (cur_rtr ? RTR_FLAG : 32'h0);
    f.len  = data_len;
    f.data = data_acc;
    frames_due.push_back(f);
  endtask

  task automatic start_command(input logic [7:0] c);
    if (c == CH_CR) begin
      cur_phase = PH_IDLE;
    end else if (c == CH_STD || c == CH_EXT || c == CH_STDRTR || c == CH_EXTRTR) begin
      cur_ext   = ~c[5];
      cur_rtr   = ((c | CH_LOWER) == CH_STDRTR);
      id_acc    = '0;
      id_digits = '0;
      data_len  = '0;
      data_acc  = '0;
      nibbles   = '0;
      cur_phase = PH_ID;
    end else begin
      cur_phase = PH_DISCARD;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] v;
    int sh;
    v = digit_value(c);
    case (cur_phase)
      PH_DISCARD: begin
        if (c == CH_CR) cur_phase = PH_IDLE;
      end
      PH_ID: begin
        if (v[4]) begin
          cur_phase = PH_IDLE;
        end else begin
          id_acc    = {id_acc[27:0], v[3:0]};
          id_digits = id_digits + 4'd1;
          if (id_digits >= (cur_ext ? EXT_ID_DIGITS : STD_ID_DIGITS)) cur_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (cur_rtr) begin
          data_len  = '0;
          data_acc  = '0;
          queue_frame();
          cur_phase = PH_IDLE;
          if (c != CH_ZERO) start_command(c);
        end else if (c < CH_ZERO || c > CH_EIGHT) begin
          cur_phase = PH_IDLE;
        end else begin
          data_len = 4'(c - CH_ZERO);
          data_acc = '0;
          nibbles  = '0;
          if (data_len == 4'd0) begin
            queue_frame();
            cur_phase = PH_IDLE;
          end else begin
            cur_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (v[4] || nibbles > 5'd15) begin
          cur_phase = PH_IDLE;
        end else begin
          sh = 8 * int'(nibbles >> 1) + (nibbles[0] ? 0 : 4);
          data_acc = data_acc | (64'(v[3:0]) << sh);
          nibbles  = nibbles + 5'd1;
          if (nibbles >= 5'(2 * data_len)) begin
            queue_frame();
            cur_phase = PH_IDLE;
          end
        end
      end
      default: start_command(c);
    endcase
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk); while (!in_ready);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (frames_due.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (frames_due.size() != 0) begin
      $error("%0d expected frames never arrived", frames_due.size());
      errors++;
      frames_due.delete();
    end
  endtask

  task automatic check_frame();
    frame_t f;
    if (frames_due.size() == 0) begin
      $error("unexpected frame id=%h len=%0d data=%h", frame_id, frame_len, frame_data);
      errors++;
    end else begin
      f = frames_due.pop_front();
      frames_seen++;
      if (frame_id !== f.id) begin
        $error("frame_id: expected %h, got %h", f.id, frame_id);
        errors++;
      end
      if (frame_len !== f.len) begin
        $error("frame_len: expected %0d, got %0d", f.len, frame_len);
        errors++;
      end
      if (frame_data !== f.data) begin
        $error("frame_data: expected %h, got %h", f.data, frame_data);
        errors++;
      end
    end
  endtask

  // result side: per-frame random stall plus optional long hold
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_frame();
        stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one random command line, mostly well formed
  task automatic send_random_line();
    logic [7:0] line[$];
    logic [7:0] cmd;
    int ndig, len, sel, pos;
    bit close_cr;
    case ($urandom_range(0, 3))
      0:       cmd = CH_STD;
      1:       cmd = CH_EXT;
      2:       cmd = CH_STDRTR;
      default: cmd = CH_EXTRTR;
    endcase
    line.push_back(cmd);
    ndig = cmd[5] ? int'(STD_ID_DIGITS) : int'(EXT_ID_DIGITS);
    for (int i = 0; i < ndig; i++) line.push_back(rand_hex_char());
    close_cr = ($urandom_range(0, 1) == 1);
    if (cmd == CH_STDRTR || cmd == CH_EXTRTR) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        line.push_back(CH_ZERO);
      end else if (sel < 7) begin
        line.push_back(CH_CR);
        close_cr = 1'b0;
      end else if (sel < 8) begin
        line.push_back(8'($urandom_range(8'h31, 8'h39)));
        close_cr = 1'b1;
      end else begin
        // next line's command byte lands in the length slot
        close_cr = 1'b0;
      end
    end else begin
      len = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 8);
      line.push_back(CH_ZERO + 8'(len));
      for (int i = 0; i < 2 * len; i++) line.push_back(rand_hex_char());
    end
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, line.size() - 1);
      line[pos] = 8'($urandom_range(0, 255));
    end
    if (close_cr) line.push_back(CH_CR);
    foreach (line[i]) send_char(line[i]);
    line_chars += line.size();
  endtask

  task automatic send_noise();
    int n;
    if ($urandom_range(0, 1) == 1) begin
      send_char(8'($urandom_range(0, 255)));
    end else begin
      send_char("?");
      n = $urandom_range(0, 5);
      repeat (n) send_char(8'($urandom_range(0, 255)));
      send_char(CH_CR);
    end
  endtask

  task automatic test_special_cases();
    send_char(CH_CR);             // stray carriage return
    send_text("t0000");           // smallest standard frame
    send_text("T000000000");      // extended, no data
    send_text("RFFFFFFFFr");      // id overlaps flags; non-zero length byte restarts
    send_text("7FF");
    send_char(CH_CR);             // remote length slot holds a carriage return
    send_text("t12z");            // bad id digit
    send_text("t1239");           // length out of range
    send_text("t0011g");          // bad data digit
    send_text("x?");              // unknown command, discarded
    send_char(8'hFF);
    send_char(CH_CR);
    send_char(8'h00);
    send_char(CH_CR);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int target);
    int lines;
    lines = 0;
    while (line_chars < target) begin
      if (lines % 30 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_line();
      lines++;
      if (lines % 97 == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    repeat (20) begin
      send_text("t1230");
      send_text("TABCDEF012");
      send_text("1122");
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_random_line();
      send_char(CH_CR);
      wait_drained();
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    cur_phase = PH_IDLE;
    cur_ext   = 1'b0;
    cur_rtr   = 1'b0;
    id_acc    = '0;
    id_digits = '0;
    data_len  = '0;
    data_acc  = '0;
    nibbles   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_output_backpressure();
    test_random_traffic(1330);
    test_drain_pause();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Fed %0d characters; compared %0d frames (t/T/r/R, bad digits, discards,",
             chars_sent, frames_seen);
    $display("remote restarts, long output stall and drain pauses).");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slcp_pkg.sv
rtl/slcp_step.sv
rtl/slcan_ascii_to_can_frame_parser_core.sv
dv/tb_slcan_ascii_to_can_frame_parser_core.sv
